### src/gbv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, byte range bounds and range-test helpers for the GB18030 validator.
// No dependencies.

package gbv_pkg;

   // Sequence position codes
   localparam logic [1:0] POS_BOUNDARY = 2'd0;
   localparam logic [1:0] POS_LEAD     = 2'd1;
   localparam logic [1:0] POS_THIRD    = 2'd2;
   localparam logic [1:0] POS_FOURTH   = 2'd3;

   localparam logic [7:0] SINGLE_MAX     = 8'h7F;
   localparam logic [7:0] TWO_A_LEAD_LO  = 8'hB0;
   localparam logic [7:0] TWO_A_LEAD_HI  = 8'hF7;
   localparam logic [7:0] TWO_A_TRAIL_LO = 8'hA1;
   localparam logic [7:0] TWO_A_TRAIL_HI = 8'hFE;
   localparam logic [7:0] TWO_B_LEAD_LO  = 8'h81;
   localparam logic [7:0] TWO_B_LEAD_HI  = 8'hA0;
   localparam logic [7:0] TWO_B_TRAIL_LO = 8'h40;
   localparam logic [7:0] TWO_B_TRAIL_HI = 8'hFE;
   localparam logic [7:0] TWO_C_LEAD_LO  = 8'hAA;
   localparam logic [7:0] TWO_C_LEAD_HI  = 8'hFE;
   localparam logic [7:0] TWO_C_TRAIL_LO = 8'h40;
   localparam logic [7:0] TWO_C_TRAIL_HI = 8'hA0;
   localparam logic [7:0] FOUR_LEAD_A_LO = 8'h81;
   localparam logic [7:0] FOUR_LEAD_A_HI = 8'h82;
   localparam logic [7:0] FOUR_LEAD_B_LO = 8'h95;
   localparam logic [7:0] FOUR_LEAD_B_HI = 8'h98;
   localparam logic [7:0] DIGIT_LO       = 8'h30;
   localparam logic [7:0] DIGIT_HI       = 8'h39;
   localparam logic [7:0] FOUR_MID_LO    = 8'h81;
   localparam logic [7:0] FOUR_MID_HI    = 8'hFE;

   typedef struct packed {
      logic [1:0] seq_position;
      logic [7:0] lead_byte;
      logic       parse_failed;
   } gbv_state_type;

   localparam gbv_state_type STATE_RESET = '{
      seq_position: POS_BOUNDARY,
      lead_byte:    8'h00,
      parse_failed: 1'b0
   };

   function automatic logic in_range(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
      return v inside {[lo:hi]};
   endfunction

   function automatic logic is_four_lead(logic [7:0] b);
      return in_range(b, FOUR_LEAD_A_LO, FOUR_LEAD_A_HI)
          || in_range(b, FOUR_LEAD_B_LO, FOUR_LEAD_B_HI);
   endfunction

   function automatic logic is_two_pair(logic [7:0] lead, logic [7:0] trail);
      return (in_range(lead, TWO_A_LEAD_LO, TWO_A_LEAD_HI)
              && in_range(trail, TWO_A_TRAIL_LO, TWO_A_TRAIL_HI))
          || (in_range(lead, TWO_B_LEAD_LO, TWO_B_LEAD_HI)
              && in_range(trail, TWO_B_TRAIL_LO, TWO_B_TRAIL_HI))
          || (in_range(lead, TWO_C_LEAD_LO, TWO_C_LEAD_HI)
              && in_range(trail, TWO_C_TRAIL_LO, TWO_C_TRAIL_HI));
   endfunction

endpackage

`default_nettype wire

### src/gbv_stream_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the byte input and the verdict output.
// No dependencies.

interface gbv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;
   logic       no_byte;

   modport source (output valid, output data_byte, output end_of_text, output no_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input end_of_text, input no_byte,
                   output ready);
endinterface

interface gbv_rsp_if;
   logic valid;
   logic ready;
   logic text_valid;

   modport source (output valid, output text_valid, input ready);
   modport sink   (input valid, input text_valid, output ready);
endinterface

`default_nettype wire

### src/gbv_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Next-state and verdict logic for one item of the byte stream.
// Depends on gbv_pkg.

module gbv_step
   import gbv_pkg::*;
(
   input  wire gbv_state_type cur_state,
   input  wire logic [7:0]    data_byte,
   input  wire logic          end_of_text,
   input  wire logic          no_byte,
   output gbv_state_type      next_state,
   output logic               text_valid
);

   gbv_state_type after_byte;

   always_comb begin
      after_byte = cur_state;
      if (!no_byte && !cur_state.parse_failed) begin
         case (cur_state.seq_position)
            POS_BOUNDARY: begin
               if (data_byte <= SINGLE_MAX) begin
                  after_byte.seq_position = POS_BOUNDARY;
               end else if (in_range(data_byte, TWO_B_LEAD_LO, TWO_B_LEAD_HI)
                            || in_range(data_byte, TWO_C_LEAD_LO, TWO_C_LEAD_HI)) begin
                  after_byte.lead_byte    = data_byte;
                  after_byte.seq_position = POS_LEAD;
               end else begin
                  after_byte.parse_failed = 1'b1;
               end
            end
            POS_LEAD: begin
               if (in_range(data_byte, DIGIT_LO, DIGIT_HI) && is_four_lead(cur_state.lead_byte)) begin
                  after_byte.seq_position = POS_THIRD;
               end else if (is_two_pair(cur_state.lead_byte, data_byte)) begin
                  after_byte.seq_position = POS_BOUNDARY;
               end else begin
                  after_byte.parse_failed = 1'b1;
               end
            end
            POS_THIRD: begin
               if (in_range(data_byte, FOUR_MID_LO, FOUR_MID_HI)) begin
                  after_byte.seq_position = POS_FOURTH;
               end else begin
                  after_byte.parse_failed = 1'b1;
               end
            end
            default: begin
               if (in_range(data_byte, DIGIT_LO, DIGIT_HI)) begin
                  after_byte.seq_position = POS_BOUNDARY;
               end else begin
                  after_byte.parse_failed = 1'b1;
               end
            end
         endcase
      end

      text_valid = !after_byte.parse_failed && (after_byte.seq_position == POS_BOUNDARY);
      // closing item returns the parser to its reset state for the next string
      next_state = end_of_text ? STATE_RESET : after_byte;
   end

endmodule

`default_nettype wire

### src/gb18030_byte_stream_validator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the GB18030 byte stream validator.
// Depends on gbv_pkg, gbv_stream_ifs (gbv_req_if, gbv_rsp_if) and gbv_step.

// The block checks a string, one byte per transfer on req_chan, against the
// GB18030 sequence rules (one-, two- and four-byte forms) and gives a single
// verdict transfer on rsp_chan for each string, on the item with end_of_text
// set. An item with no_byte set carries no byte; with end_of_text it just
// closes the string (so an empty string is valid), without it it does nothing.
// Throughput is one item per clock unless a closing item stalls: each item is
// held in an input register while the range checks update the parser state,
// and a verdict lands in an output register, from which it is valid on
// rsp_chan. The only stall is a closing item that meets a verdict not yet
// taken; bytes that close nothing never stall on their own, though they
// queue behind a closing item that waits.
// After a verdict the parser is back at its reset state for the next string.

module gb18030_byte_stream_validator_top
   import gbv_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   gbv_req_if.sink   req_chan,
   gbv_rsp_if.source rsp_chan
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_data_byte_ff;
   logic       in_end_of_text_ff;
   logic       in_no_byte_ff;

   // parser state
   gbv_state_type state_ff;
   gbv_state_type state_in;

   // output register
   logic out_valid_ff;
   logic out_valid_in;
   logic out_text_valid_ff;
   logic out_text_valid_in;

   logic step_text_valid;
   logic stage_go;
   logic out_blocked;

   gbv_step u_step (
      .cur_state   (state_ff),
      .data_byte   (in_data_byte_ff),
      .end_of_text (in_end_of_text_ff),
      .no_byte     (in_no_byte_ff),
      .next_state  (state_in),
      .text_valid  (step_text_valid)
   );

   // a closing item can only move on if the output register is free or being read this cycle
   assign out_blocked = out_valid_ff && !rsp_chan.ready;
   assign stage_go    = in_valid_ff && !(in_end_of_text_ff && out_blocked);

   assign req_chan.ready = !in_valid_ff || stage_go;

   always_comb begin
      out_valid_in      = out_valid_ff && !rsp_chan.ready;
      out_text_valid_in = out_text_valid_ff;
      if (stage_go && in_end_of_text_ff) begin
         out_valid_in      = 1'b1;
         out_text_valid_in = step_text_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (stage_go) begin
            state_ff <= state_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_byte_ff   <= req_chan.data_byte;
         in_end_of_text_ff <= req_chan.end_of_text;
         in_no_byte_ff     <= req_chan.no_byte;
      end
      out_text_valid_ff <= out_text_valid_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.text_valid = out_text_valid_ff;

endmodule

`default_nettype wire
